@@ src/prq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared command and status codes and the front-to-back command record.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam logic [2:0] CMD_PUSH     = 3'd0;
  localparam logic [2:0] CMD_POP_OLD  = 3'd1;
  localparam logic [2:0] CMD_POP_RUN  = 3'd2;
  localparam logic [2:0] CMD_PEEK_OLD = 3'd3;
  localparam logic [2:0] CMD_PEEK_RUN = 3'd4;
  localparam logic [2:0] CMD_ERASE    = 3'd5;
  // codes with no operation behind them
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // classified command passed from front to back
  typedef struct packed {
    logic       is_push;
    logic       is_pop;
    logic       is_peek;
    logic       is_erase;
    logic       oldest;
  } cmd_class_t;

endpackage

@@ src/prq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/prq_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_front
// Accepts command beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module prq_front
  import prq_pkg::*;
#(
  parameter int RUN_BITS  = 16,
  parameter int SLOT_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           cmd,
  input  logic [RUN_BITS-1:0]  run,
  input  logic [SLOT_BITS-1:0] task_slot,
  output logic                 q_valid,
  input  logic                 q_take,
  output cmd_class_t           q_cls,
  output logic [RUN_BITS-1:0]  q_run,
  output logic [SLOT_BITS-1:0] q_slot
);

  cmd_class_t           cls_mem  [2];
  logic [RUN_BITS-1:0]  run_mem  [2];
  logic [SLOT_BITS-1:0] slot_mem [2];
  logic                 wptr;
  logic                 rptr;
  logic [1:0]           cnt;
  cmd_class_t           cls_in;
  logic                 wr;
  logic                 rd;

  // decode the command code
  always_comb begin
    cls_in = '0;
    case (cmd)
      CMD_PUSH:     cls_in.is_push = 1'b1;
      CMD_POP_OLD:  begin cls_in.is_pop = 1'b1; cls_in.oldest = 1'b1; end
      CMD_POP_RUN:  cls_in.is_pop = 1'b1;
      CMD_PEEK_OLD: begin cls_in.is_peek = 1'b1; cls_in.oldest = 1'b1; end
      CMD_PEEK_RUN: cls_in.is_peek = 1'b1;
      CMD_ERASE:    cls_in.is_erase = 1'b1;
      default:      cls_in = '0;
    endcase
  end

  assign full    = cnt[1];
  assign wr      = push && !full;
  assign rd      = q_take && q_valid;
  assign q_valid = cnt != 2'd0;
  assign q_cls   = cls_mem[rptr];
  assign q_run   = run_mem[rptr];
  assign q_slot  = slot_mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      cls_mem[wptr]  <= cls_in;
      run_mem[wptr]  <= run;
      slot_mem[wptr] <= task_slot;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

@@ src/prq_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_back
// Sequencer that executes one command on the run table, order list and
// linked entry store, and leaves the result in an output register.
// ----------------------------------------------------------------------------
module prq_back
  import prq_pkg::*;
#(
  parameter int MAX_RUNS  = 16,
  parameter int CAPACITY  = 256,
  parameter int SLOT_BITS = 10,
  parameter int RUN_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  cmd_class_t           q_cls,
  input  logic [RUN_BITS-1:0]  q_run,
  input  logic [SLOT_BITS-1:0] q_slot,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status,
  output logic [SLOT_BITS-1:0] head_slot,
  output logic                 all_empty,
  output logic                 run_empty
);

  localparam int RI = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int EI = $clog2(CAPACITY);
  localparam int CB = $clog2(CAPACITY + 1);
  localparam int OB = $clog2(MAX_RUNS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_EXEC  = 7'b0010000,
    S_SHIFT = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // run descriptors in flops
  logic                desc_valid [MAX_RUNS];
  logic [RUN_BITS-1:0] desc_id    [MAX_RUNS];
  logic [EI-1:0]       desc_head  [MAX_RUNS];
  logic [EI-1:0]       desc_tail  [MAX_RUNS];
  logic [CB-1:0]       desc_cnt   [MAX_RUNS];
  logic [RI-1:0]       order_list [MAX_RUNS];
  logic [OB-1:0]       order_count;
  logic [EI-1:0]       free_head;
  logic [CB-1:0]       free_count;

  // current command
  cmd_class_t           cur_cls;
  logic [RUN_BITS-1:0]  cur_run;
  logic [SLOT_BITS-1:0] cur_slot;
  logic [1:0]           wstat;
  logic [SLOT_BITS-1:0] whead;
  logic                 hit;
  logic [RI-1:0]        hit_idx;
  logic                 has_free;
  logic [RI-1:0]        free_idx;
  logic [RI-1:0]        tgt;
  logic [RI-1:0]        shift_pos;

  // init sweep of the link store
  logic          init_busy;
  logic [EI-1:0] init_ptr;

  // memories
  logic                 nx_we;
  logic [EI-1:0]        nx_waddr;
  logic [EI-1:0]        nx_wdata;
  logic [EI-1:0]        nx_raddr;
  logic [EI-1:0]        nx_rdata;
  logic [EI-1:0]        nx_rdata_free;
  logic                 sl_we;
  logic [EI-1:0]        sl_waddr;
  logic [EI-1:0]        sl_raddr;
  logic [SLOT_BITS-1:0] sl_rdata;

  // result register
  logic                 res_valid;

  // lookup results over the descriptor table
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = MAX_RUNS - 1; i >= 0; i--) begin
      if (desc_valid[i] && desc_id[i] == cur_run) begin
        hit = 1'b1;
        hit_idx = RI'(i);
      end
      if (!desc_valid[i]) begin
        has_free = 1'b1;
        free_idx = RI'(i);
      end
    end
  end

  prq_ram #(.WIDTH(EI), .DEPTH(CAPACITY)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  prq_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_slots (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(cur_slot),
    .raddr(sl_raddr), .rdata(sl_rdata)
  );

  logic do_push;
  logic do_pop;
  logic do_erase;
  logic push_ok;
  logic [EI-1:0] init_succ;

  assign init_succ = (32'(init_ptr) + 1 < CAPACITY) ? init_ptr + EI'(1) : '0;
  assign push_ok   = (free_count != '0) && (hit || has_free);
  assign do_push   = state == S_EXEC && cur_cls.is_push && push_ok;
  assign do_pop    = state == S_EXEC && cur_cls.is_pop && wstat == ST_DONE;
  assign do_erase  = state == S_EXEC && cur_cls.is_erase && wstat == ST_DONE;

  // memory port steering
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = desc_tail[tgt];
    nx_wdata = free_head;
    nx_raddr = (state == S_LOOK) ? free_head : desc_head[tgt];
    sl_we    = do_push;
    sl_waddr = free_head;
    sl_raddr = desc_head[tgt];
    if (init_busy) begin
      nx_we    = 1'b1;
      nx_waddr = init_ptr;
      nx_wdata = init_succ;
    end else if (do_push && hit) begin
      nx_we    = 1'b1;
      nx_waddr = desc_tail[tgt];
      nx_wdata = free_head;
    end else if (do_pop && free_count != '0) begin
      nx_we    = 1'b1;
      nx_waddr = desc_head[tgt];
      nx_wdata = free_head;
    end else if (do_erase && free_count != '0) begin
      nx_we    = 1'b1;
      nx_waddr = desc_tail[tgt];
      nx_wdata = free_head;
    end
  end

  assign q_take = state == S_IDLE && !init_busy && q_valid;
  assign empty  = !res_valid;

  // tail-end run-empty flag recomputed after the command
  logic post_hit;
  always_comb begin
    post_hit = 1'b0;
    for (int i = 0; i < MAX_RUNS; i++) begin
      if (desc_valid[i] && desc_id[i] == cur_run) post_hit = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      init_busy   <= 1'b1;
      init_ptr    <= '0;
      order_count <= '0;
      free_head   <= '0;
      free_count  <= CB'(CAPACITY);
      res_valid   <= 1'b0;
      for (int i = 0; i < MAX_RUNS; i++) desc_valid[i] <= 1'b0;
    end else begin
      if (init_busy) begin
        init_ptr <= init_ptr + EI'(1);
        if (32'(init_ptr) == CAPACITY - 1) init_busy <= 1'b0;
      end
      // result beat load and hand-off
      if (state == S_OUT && (!res_valid || pop)) res_valid <= 1'b1;
      else if (res_valid && pop) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_take) begin
            cur_cls  <= q_cls;
            cur_run  <= q_run;
            cur_slot <= q_slot;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          // pick target descriptor and preliminary status
          whead <= '0;
          if (cur_cls.is_push) begin
            tgt   <= hit ? hit_idx : free_idx;
            wstat <= push_ok ? ST_DONE : ST_FULL;
          end else if (cur_cls.oldest) begin
            tgt   <= order_list[0];
            wstat <= (order_count != '0 && (cur_cls.is_pop || cur_cls.is_peek)) ?
                     ST_DONE : ST_NONE;
          end else begin
            tgt   <= hit_idx;
            wstat <= (hit && (cur_cls.is_pop || cur_cls.is_peek || cur_cls.is_erase)) ?
                     ST_DONE : ST_NONE;
          end
          state <= S_READ;
        end
        S_READ: state <= S_WAIT;
        S_WAIT: state <= S_EXEC;
        S_EXEC: begin
          if (do_push) begin
            free_head  <= nx_rdata_free;
            free_count <= free_count - CB'(1);
            if (!hit) begin
              desc_valid[tgt] <= 1'b1;
              desc_id[tgt]    <= cur_run;
              desc_head[tgt]  <= free_head;
              desc_cnt[tgt]   <= CB'(1);
              order_list[order_count[RI-1:0]] <= tgt;
              order_count <= order_count + OB'(1);
            end else begin
              desc_cnt[tgt] <= desc_cnt[tgt] + CB'(1);
            end
            desc_tail[tgt] <= free_head;
          end else if (wstat == ST_DONE && (cur_cls.is_pop || cur_cls.is_peek)) begin
            whead <= sl_rdata;
            if (cur_cls.is_pop) begin
              desc_head[tgt] <= nx_rdata;
              free_head      <= desc_head[tgt];
              free_count     <= free_count + CB'(1);
              desc_cnt[tgt]  <= desc_cnt[tgt] - CB'(1);
              if (desc_cnt[tgt] == CB'(1)) desc_valid[tgt] <= 1'b0;
            end
          end else if (do_erase) begin
            free_head       <= desc_head[tgt];
            free_count      <= free_count + desc_cnt[tgt];
            desc_valid[tgt] <= 1'b0;
          end
          // a run that went away leaves the order list
          if ((do_pop && desc_cnt[tgt] == CB'(1)) || do_erase) begin
            shift_pos <= '0;
            state     <= S_SHIFT;
          end else begin
            state <= S_OUT;
          end
        end
        S_SHIFT: begin
          // remove tgt from the order list, one position per cycle
          if (32'(shift_pos) >= 32'(order_count)) begin
            state <= S_OUT;
          end else if (order_list[shift_pos] == tgt) begin
            for (int i = 0; i < MAX_RUNS - 1; i++) begin
              if (i >= 32'(shift_pos)) order_list[i] <= order_list[i + 1];
            end
            order_count <= order_count - OB'(1);
            state <= S_OUT;
          end else begin
            shift_pos <= shift_pos + RI'(1);
          end
        end
        S_OUT: begin
          if (!res_valid || pop) begin
            status    <= wstat;
            head_slot <= whead;
            all_empty <= order_count == '0;
            run_empty <= !post_hit;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // link read for push: the free head address is presented in S_LOOK and the RAM read data is captured in S_READ
  always_ff @(posedge clk) begin
    if (state == S_READ) nx_rdata_free <= nx_rdata;
  end

endmodule

@@ src/per_run_ordered_ready_queue.sv @@
`timescale 1ns / 1ps
// The order-list removal walks one position per cycle after a run empties
//   or is erased. The back sequencer takes one command at a time and no
//   new one until the last result is loaded into the output register.
// Reset: synchronous; after reset the link store is chained over all
//   CAPACITY entries before the first command is taken.
// ----------------------------------------------------------------------------
// per_run_ordered_ready_queue
// Per-run FIFOs of task slots with a creation-ordered run list.
// ----------------------------------------------------------------------------
module per_run_ordered_ready_queue
  import prq_pkg::*;
#(
  parameter int MAX_RUNS  = 16,
  parameter int CAPACITY  = 256,
  parameter int SLOT_BITS = 10,
  parameter int RUN_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           cmd,
  input  logic [RUN_BITS-1:0]  run,
  input  logic [SLOT_BITS-1:0] task_slot,
  output logic                 empty,
  input  logic                 pop,
  output logic [1:0]           status,
  output logic [SLOT_BITS-1:0] head_slot,
  output logic                 all_empty,
  output logic                 run_empty
);

  logic                 q_valid;
  logic                 q_take;
  cmd_class_t           q_cls;
  logic [RUN_BITS-1:0]  q_run;
  logic [SLOT_BITS-1:0] q_slot;

  prq_front #(.RUN_BITS(RUN_BITS), .SLOT_BITS(SLOT_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .run(run),
    .task_slot(task_slot), .q_valid(q_valid), .q_take(q_take),
    .q_cls(q_cls), .q_run(q_run), .q_slot(q_slot)
  );

  prq_back #(
    .MAX_RUNS(MAX_RUNS), .CAPACITY(CAPACITY),
    .SLOT_BITS(SLOT_BITS), .RUN_BITS(RUN_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take),
    .q_cls(q_cls), .q_run(q_run), .q_slot(q_slot), .empty(empty), .pop(pop),
    .status(status), .head_slot(head_slot), .all_empty(all_empty),
    .run_empty(run_empty)
  );

  // result beat holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(head_slot)))
    else $error("result changed while stalled");

  // no slot reported unless the command completed
  a_slot: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_DONE) |-> head_slot == '0)
    else $error("head slot set on failed command");

  // status code stays within the defined set
  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_DONE || status == ST_NONE || status == ST_FULL))
    else $error("bad status code");

endmodule

@@ tb/sv/tb_per_run_ordered_ready_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_run_ordered_ready_queue
// Drives command beats into the per-run ready queue and checks each result
// beat against a predictor that keeps per-run slot fifos, the creation order
// of runs and the store fill level. Directed tests cover empty and unknown
// runs, the all-ones run id, unused codes, the run table and store limits
// with a long receiver hold-off, then random mixed traffic with idle bursts.
// ----------------------------------------------------------------------------
module tb_per_run_ordered_ready_queue;
  import prq_pkg::*;

  localparam int NRUNS = 16;
  localparam int NCAP  = 256;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0] status;
    logic [9:0] head_slot;
    logic       all_empty;
    logic       run_empty;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  cmd = CMD_PUSH;
  logic [15:0] run = '0;
  logic [9:0]  task_slot = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status;
  logic [9:0]  head_slot;
  logic        all_empty;
  logic        run_empty;

  // predictor state
  logic        run_valid [NRUNS];
  logic [15:0] run_id    [NRUNS];
  logic [9:0]  run_fifo  [NRUNS][$];
  int          run_order [$];
  int          entries_used;

  result_t     expected_results [$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  per_run_ordered_ready_queue dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd), .run(run),
    .task_slot(task_slot), .empty(empty), .pop(pop), .status(status),
    .head_slot(head_slot), .all_empty(all_empty), .run_empty(run_empty)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** per_run_ordered_ready_queue: FAILED **");
      $finish;
    end
  end

  function automatic int find_run(logic [15:0] id);
    for (int i = 0; i < NRUNS; i++)
      if (run_valid[i] && run_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_from_order(int idx);
    for (int i = 0; i < run_order.size(); i++)
      if (run_order[i] == idx) begin
        run_order.delete(i);
        return;
      end
  endfunction

  function automatic logic [9:0] take_head(int idx);
    logic [9:0] v;
    v = run_fifo[idx][0];
    run_fifo[idx].delete(0);
    entries_used--;
    if (run_fifo[idx].size() == 0) begin
      run_valid[idx] = 1'b0;
      drop_from_order(idx);
    end
    return v;
  endfunction

  // work out the result of one accepted command
  function automatic result_t queue_outcome(logic [2:0] c, logic [15:0] id,
                                            logic [9:0] slot);
    result_t r;
    int idx;
    int d;
    r.status = ST_NONE;
    r.head_slot = '0;
    idx = find_run(id);
    case (c)
      CMD_PUSH: begin
        d = idx;
        if (d < 0)
          for (int i = NRUNS - 1; i >= 0; i--) if (!run_valid[i]) d = i;
        if (entries_used == NCAP || d < 0) begin
          r.status = ST_FULL;
        end else begin
          run_fifo[d].insert(run_fifo[d].size(), slot);
          entries_used++;
          if (idx < 0) begin
            run_valid[d] = 1'b1;
            run_id[d] = id;
            run_order.insert(run_order.size(), d);
          end
          r.status = ST_DONE;
        end
      end
      CMD_POP_OLD, CMD_PEEK_OLD: begin
        if (run_order.size() > 0) begin
          d = run_order[0];
          r.head_slot = (c == CMD_POP_OLD) ? take_head(d) : run_fifo[d][0];
          r.status = ST_DONE;
        end
      end
      CMD_POP_RUN, CMD_PEEK_RUN: begin
        if (idx >= 0) begin
          r.head_slot = (c == CMD_POP_RUN) ? take_head(idx) : run_fifo[idx][0];
          r.status = ST_DONE;
        end
      end
      CMD_ERASE: begin
        if (idx >= 0) begin
          entries_used -= run_fifo[idx].size();
          run_fifo[idx].delete();
          run_valid[idx] = 1'b0;
          drop_from_order(idx);
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.all_empty = (run_order.size() == 0);
    r.run_empty = (find_run(id) < 0);
    return r;
  endfunction

  // send one command beat, with an optional idle burst ahead of it
  task automatic send_beat(logic [2:0] c, logic [15:0] id, logic [9:0] slot);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    run <= id;
    task_slot <= slot;
    do @(posedge clk); while (full);
    expected_results.insert(expected_results.size(), queue_outcome(c, id, slot));
  endtask

  // result side: random idle bursts and a long hold when requested
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (600) @(negedge clk);
        hold_req = 1'b0;
      end
      if (idle > 0) begin
        idle--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    result_t e;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_results[0];
        expected_results.delete(0);
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (head_slot !== e.head_slot) begin
          $error("head_slot expected %0d actual %0d", e.head_slot, head_slot);
          errors++;
        end
        if (all_empty !== e.all_empty) begin
          $error("all_empty expected %0d actual %0d", e.all_empty, all_empty);
          errors++;
        end
        if (run_empty !== e.run_empty) begin
          $error("run_empty expected %0d actual %0d", e.run_empty, run_empty);
          errors++;
        end
      end
    end
  end

  // empty queue, unknown runs and unused codes
  task automatic test_empty_and_unknown();
    send_beat(CMD_POP_OLD, 16'h0000, 10'h000);
    send_beat(CMD_PEEK_OLD, 16'hFFFF, 10'h3FF);
    send_beat(CMD_POP_RUN, 16'h1234, 10'h000);
    send_beat(CMD_PEEK_RUN, 16'hFFFF, 10'h000);
    send_beat(CMD_ERASE, 16'h0007, 10'h000);
    send_beat(CMD_UNUSED_A, 16'h0001, 10'h155);
    send_beat(CMD_UNUSED_B, 16'hFFFF, 10'h2AA);
  endtask

  // every command on a few runs, the all-ones run id and field extremes
  task automatic test_basic_commands();
    send_beat(CMD_PUSH, 16'hFFFF, 10'h3FF);
    send_beat(CMD_PUSH, 16'h0000, 10'h000);
    send_beat(CMD_PUSH, 16'hFFFF, 10'h155);
    send_beat(CMD_PUSH, 16'h5A5A, 10'h2AA);
    send_beat(CMD_PEEK_OLD, 16'h0000, 10'h000);
    send_beat(CMD_PEEK_RUN, 16'h0000, 10'h000);
    send_beat(CMD_POP_OLD, 16'h0000, 10'h000);
    send_beat(CMD_POP_RUN, 16'h0000, 10'h000);
    send_beat(CMD_POP_OLD, 16'hFFFF, 10'h000);
    send_beat(CMD_ERASE, 16'h5A5A, 10'h000);
    send_beat(CMD_PEEK_OLD, 16'h0000, 10'h000);
  endtask

  // more runs than descriptors, then clear them
  task automatic test_run_table_limit();
    for (int i = 0; i < NRUNS + 2; i++)
      send_beat(CMD_PUSH, 16'h0100 + i[15:0], i[9:0]);
    for (int i = 0; i < NRUNS + 2; i++)
      send_beat(CMD_ERASE, 16'h0100 + i[15:0], 10'h000);
  endtask

  // receiver holds off while the store fills past capacity
  task automatic test_store_full_pressure();
    hold_req = 1'b1;
    for (int i = 0; i < NCAP + 6; i++)
      send_beat(CMD_PUSH, 16'(i % 3), 10'($urandom));
    for (int i = 0; i < NCAP / 2; i++)
      send_beat(CMD_POP_OLD, 16'(i % 3), 10'h000);
    for (int i = 0; i < 3; i++)
      send_beat(CMD_ERASE, 16'(i), 10'h000);
  endtask

  function automatic logic [15:0] pick_run();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 19));
  endfunction

  // random mixed traffic
  task automatic test_random_traffic(int count);
    int k;
    logic [2:0] c;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 42) c = CMD_PUSH;
      else if (k < 57) c = CMD_POP_OLD;
      else if (k < 72) c = CMD_POP_RUN;
      else if (k < 82) c = CMD_PEEK_OLD;
      else if (k < 92) c = CMD_PEEK_RUN;
      else if (k < 97) c = CMD_ERASE;
      else c = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_A : CMD_UNUSED_B;
      send_beat(c, pick_run(), 10'($urandom));
    end
  endtask

  initial begin
    int wait_cycles;
    for (int i = 0; i < NRUNS; i++) begin
      run_valid[i] = 1'b0;
      run_id[i] = '0;
    end
    entries_used = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_unknown();
    test_basic_commands();
    test_run_table_limit();
    test_store_full_pressure();
    test_random_traffic(650);
    calm = 1'b1;
    test_random_traffic(150);
    @(negedge clk);
    push <= 1'b0;

    // drain
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** per_run_ordered_ready_queue: PASSED **");
    end else begin
      $display("** per_run_ordered_ready_queue: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/prq_pkg.sv
src/prq_ram.sv
src/prq_front.sv
src/prq_back.sv
src/per_run_ordered_ready_queue.sv
tb/sv/tb_per_run_ordered_ready_queue.sv
